>>> sv/fir_filter_led_level_mapper_assert.svh
// Assertion macros for the FIR LED level mapper.
// Included by the top level; needs no package.
`ifndef FIR_FILTER_LED_LEVEL_MAPPER_ASSERT_SVH
`define FIR_FILTER_LED_LEVEL_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define FFLM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FFLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/fflm_pkg.sv
// Shared types, constants and helpers of the FIR LED level mapper.
// No dependencies; the interfaces, RAM, MAC, divider and top level all use it.
package fflm_pkg;

   localparam int TAPS_DEFAULT = 49;
   localparam int TAPS_MAX     = 64;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int IDX_W    = 6;
   localparam int OUT_W    = 18;
   localparam int LED_W    = 8;
   localparam int LEVEL_W  = 5;
   localparam int PROD_W   = SAMPLE_W + COEF_W;

   localparam int COEFF_SCALE  = 100000;
   localparam int LEVEL_OFFSET = 32;

   // Quotient magnitude width and the dividend magnitude width that holds 2^QUO_W * scale.
   localparam int QUO_W = 18;
   localparam int REM_W = 35;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [OUT_W-1:0]    out_type;
   typedef logic [IDX_W-1:0]           idx_type;
   typedef logic [LED_W-1:0]           led_type;
   typedef logic [LEVEL_W-1:0]         level_type;

   localparam out_type OUT_MAX = 18'sh1FFFF;
   localparam out_type OUT_MIN = 18'sh20000;

   // Largest quotient magnitudes that still fit either bound.
   localparam logic [QUO_W-1:0] QUO_POS_MAX = 18'd131071;
   localparam logic [QUO_W-1:0] QUO_NEG_MAX = 18'd131072;

   typedef enum logic {
      OP_SAMPLE   = 1'b0,
      OP_LOAD_TAP = 1'b1
   } op_type;

   localparam logic MODE_FILTER = 1'b1;

   typedef struct packed {
      logic clear;
      logic en;
   } mac_ctrl_type;

   typedef struct packed {
      logic    done;
      out_type value;
   } div_status_type;

   // One lit LED chosen by a 3-bit position.
   function automatic led_type led_bar_of(input logic [2:0] sel);
      led_type pat;
      unique case (sel)
         3'd0:    pat = 8'h08;
         3'd1:    pat = 8'h04;
         3'd2:    pat = 8'h02;
         3'd3:    pat = 8'h01;
         3'd4:    pat = 8'h80;
         3'd5:    pat = 8'h40;
         3'd6:    pat = 8'h20;
         default: pat = 8'h10;
      endcase
      return pat;
   endfunction

endpackage

>>> sv/fflm_if.sv
// Request and response channel interfaces of the FIR LED level mapper.
// Depends on fflm_pkg for payload types.
interface fflm_req_if;
   import fflm_pkg::*;
   logic       valid;
   logic       ready;
   op_type     operation;
   sample_type sample;
   idx_type    tap_index;
   coef_type   tap_value;

   modport source (output valid, output operation, output sample, output tap_index,
                   output tap_value, input ready);
   modport sink (input valid, input operation, input sample, input tap_index,
                 input tap_value, output ready);
endinterface

interface fflm_rsp_if;
   import fflm_pkg::*;
   logic      valid;
   logic      ready;
   out_type   out_value;
   led_type   led_bar;
   level_type led_level;

   modport source (output valid, output out_value, output led_bar, output led_level,
                   input ready);
   modport sink (input valid, input out_value, input led_bar, input led_level,
                 output ready);
endinterface

>>> sv/fflm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Defaults come from fflm_pkg.
module fflm_ram #(
   parameter int WIDTH = fflm_pkg::SAMPLE_W,
   parameter int DEPTH = fflm_pkg::TAPS_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/fflm_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on fflm_pkg for operand types and the control struct.
module fflm_mac #(
   parameter int ACC_W = fflm_pkg::PROD_W + $clog2(fflm_pkg::TAPS_DEFAULT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fflm_pkg::mac_ctrl_type  ctrl,
   input  fflm_pkg::sample_type    a,
   input  fflm_pkg::coef_type      b,
   output logic signed [ACC_W-1:0] acc
);
   import fflm_pkg::*;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     pvalid_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset || ctrl.clear) begin
         pvalid_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         pvalid_ff <= ctrl.en;
         if (pvalid_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   assign acc = acc_ff;
endmodule

>>> sv/fflm_div.sv
// Divide by the coefficient scale with a registered reciprocal multiply, with saturation.
// Depends on fflm_pkg for widths, bounds and the status struct.
module fflm_div #(
   parameter int ACC_W = fflm_pkg::PROD_W + $clog2(fflm_pkg::TAPS_DEFAULT)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  dividend,
   output fflm_pkg::div_status_type status
);
   import fflm_pkg::*;

   // The scale is 2^SCALE_SHIFT times an odd factor: drop the low bits, then multiply by
   // the rounded-up reciprocal of the odd factor, exact for every magnitude below LIMIT.
   localparam int SCALE_SHIFT = 5;
   localparam int SCALE_ODD   = COEFF_SCALE >> SCALE_SHIFT;
   localparam int Y_W         = REM_W - SCALE_SHIFT;
   localparam int RECIP_W     = Y_W + 1;
   localparam int RSH         = Y_W + $clog2(SCALE_ODD);
   localparam int MUL_W       = Y_W + RECIP_W;
   localparam int MW          = (ACC_W > REM_W + 1) ? ACC_W : REM_W + 1;
   localparam logic [MW-1:0]      LIMIT = MW'(64'(COEFF_SCALE) << QUO_W);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RSH) + 64'(SCALE_ODD - 1)) / 64'(SCALE_ODD));

   logic [ACC_W-1:0] mag;
   logic [MW-1:0]    mag_ext;
   logic [MUL_W-1:0] prod_in;
   logic [QUO_W-1:0] quo;

   logic             v1_ff;
   logic             done_ff;
   logic             neg_ff;
   logic             big_ff;
   logic [Y_W-1:0]   y_ff;
   logic [MUL_W-1:0] prod_ff;

   assign mag     = dividend[ACC_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
   assign mag_ext = MW'(mag);
   assign prod_in = MUL_W'(y_ff) * MUL_W'(RECIP);
   assign quo     = prod_ff[RSH +: QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         done_ff <= v1_ff;
      end
      if (start) begin
         neg_ff <= dividend[ACC_W-1];
         big_ff <= mag_ext >= LIMIT;
         y_ff   <= mag_ext[REM_W-1:SCALE_SHIFT];
      end
      if (v1_ff) begin
         prod_ff <= prod_in;
      end
   end

   // Clamp to the nearest bound; a too-large dividend leaves the quotient bits meaningless.
   always_comb begin
      status.done = done_ff;
      if (neg_ff) begin
         status.value = (big_ff || quo > QUO_NEG_MAX) ? OUT_MIN
                                                      : out_type'(-$signed({1'b0, quo}));
      end else begin
         status.value = (big_ff || quo > QUO_POS_MAX) ? OUT_MAX : out_type'(quo);
      end
   end
endmodule

>>> sv/fir_filter_led_level_mapper.sv
// FIR LED level mapper: direct-form FIR over a circular sample RAM, LED bar and level.
// Filtered sample: one tap per cycle on the single multiplier, then the setup state, the
//   reciprocal-multiply divide, the result state and the response register; the next request
//   is taken in the same cycle that the response becomes valid.
// Raw sample: through the result state to the response register. Coefficient load: no response.
// Synchronous reset clears mode, pointers, fill count and coefficient valid bits at once.
module fir_filter_led_level_mapper #(
   parameter int TAPS = fflm_pkg::TAPS_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   fflm_req_if.sink   req_if,
   fflm_rsp_if.source rsp_if,
   input  logic   csr_we,
   input  logic   csr_wdata
);
   import fflm_pkg::*;

   `include "fir_filter_led_level_mapper_assert.svh"

   localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CW    = $clog2(TAPS + 1);
   localparam int SW    = $clog2(TAPS + 2);
   localparam int ACC_W = PROD_W + $clog2(TAPS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_PREP,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      mode_ff;

   // Delay line bookkeeping: newest entry, entries written since reset, coefficient valids.
   logic [AW-1:0]   wp_ff;
   logic [CW-1:0]   fill_ff;
   logic [TAPS-1:0] coef_valid_ff;

   // Tap sequencer.
   logic [SW-1:0] step_ff;
   logic [AW-1:0] hist_ptr_ff;
   logic [AW-1:0] tap_d_ff;
   logic          issue_d_ff;

   out_type   value_ff;
   logic      rsp_valid_ff;
   out_type   rsp_value_ff;
   led_type   rsp_pattern_ff;
   level_type rsp_level_ff;

   logic           accept;
   logic           is_sample;
   logic           tap_ok;
   logic           issue;
   logic [AW-1:0]  wp_in;
   logic [AW-1:0]  hist_ptr_in;
   logic [AW-1:0]  coef_raddr;
   logic [SAMPLE_W-1:0] hist_rdata;
   logic [COEF_W-1:0]   coef_rdata;
   logic           hist_ok;
   logic           coef_ok;
   sample_type     mac_a;
   coef_type       mac_b;
   mac_ctrl_type   mac_ctrl;
   logic signed [ACC_W-1:0] acc;
   div_status_type div_status;
   out_type        shifted;

   // Take a request only when the sequencer is idle; the response register decouples
   // the output side.
   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign is_sample    = (req_if.operation == OP_SAMPLE);
   assign tap_ok       = {1'b0, req_if.tap_index} < (IDX_W + 1)'(TAPS);

   // Advance the write pointer around the ring; walk the read pointer back toward older samples.
   assign wp_in       = (wp_ff == AW'(TAPS - 1)) ? '0 : wp_ff + AW'(1);
   assign hist_ptr_in = (hist_ptr_ff == '0) ? AW'(TAPS - 1) : hist_ptr_ff - AW'(1);

   assign issue      = (state_ff == S_MAC) && (step_ff < SW'(TAPS));
   assign coef_raddr = issue ? step_ff[AW-1:0] : '0;

   fflm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TAPS),
      .AW    (AW)
   ) u_hist_ram (
      .clock (clock),
      .we    (accept && is_sample),
      .waddr (wp_in),
      .wdata (req_if.sample),
      .raddr (hist_ptr_ff),
      .rdata (hist_rdata)
   );

   fflm_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TAPS),
      .AW    (AW)
   ) u_coef_ram (
      .clock (clock),
      .we    (accept && !is_sample && tap_ok),
      .waddr (req_if.tap_index[AW-1:0]),
      .wdata (req_if.tap_value),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   // Drop entries never written since reset: they read as zero.
   assign hist_ok = CW'(tap_d_ff) < fill_ff;
   assign coef_ok = coef_valid_ff[tap_d_ff];
   assign mac_a   = hist_ok ? $signed(hist_rdata) : '0;
   assign mac_b   = coef_ok ? $signed(coef_rdata) : '0;

   assign mac_ctrl.clear = accept;
   assign mac_ctrl.en    = issue_d_ff;

   fflm_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (acc)
   );

   fflm_div #(
      .ACC_W (ACC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_PREP),
      .dividend (acc),
      .status   (div_status)
   );

   // LED bar from bits 8..6 and level from bits 5..1 of the offset value.
   assign shifted = value_ff - out_type'(LEVEL_OFFSET);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= 1'b0;
         wp_ff         <= '0;
         fill_ff       <= '0;
         coef_valid_ff <= '0;
         step_ff       <= '0;
         hist_ptr_ff   <= '0;
         tap_d_ff      <= '0;
         issue_d_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end

         issue_d_ff <= issue;
         if (issue) begin
            tap_d_ff <= step_ff[AW-1:0];
         end

         // Drop a taken response unless a new one replaces it this cycle.
         if (rsp_valid_ff && rsp_if.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept && !is_sample && tap_ok) begin
                  coef_valid_ff[req_if.tap_index[AW-1:0]] <= 1'b1;
               end
               if (accept && is_sample) begin
                  wp_ff <= wp_in;
                  if (fill_ff != CW'(TAPS)) begin
                     fill_ff <= fill_ff + CW'(1);
                  end
                  if (mode_ff == MODE_FILTER) begin
                     hist_ptr_ff <= wp_in;
                     step_ff     <= '0;
                     state_ff    <= S_MAC;
                  end else begin
                     value_ff <= out_type'(req_if.sample);
                     state_ff <= S_DONE;
                  end
               end
            end
            S_MAC: begin
               // Issue one tap per cycle, then let the product and accumulate stages drain.
               if (issue) begin
                  hist_ptr_ff <= hist_ptr_in;
               end
               if (step_ff == SW'(TAPS + 1)) begin
                  state_ff <= S_PREP;
               end else begin
                  step_ff <= step_ff + SW'(1);
               end
            end
            S_PREP: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_status.done) begin
                  value_ff <= div_status.value;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // Hold the result until the response slot is free.
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_value_ff   <= value_ff;
                  rsp_pattern_ff <= led_bar_of(shifted[8:6]);
                  rsp_level_ff   <= shifted[5:1];
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_value = rsp_value_ff;
   assign rsp_if.led_bar   = rsp_pattern_ff;
   assign rsp_if.led_level = rsp_level_ff;

   `FFLM_ASSERT_NEXT(a_sample_goes_busy, clock, reset, accept && is_sample,
      state_ff != S_IDLE, "sample request did not start processing")
   `FFLM_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= CW'(TAPS), "fill count beyond tap count")
   `FFLM_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_status.done,
      state_ff == S_DIV, "divider finished outside the divide phase")
   `FFLM_ASSERT_NEXT(a_done_loads_rsp, clock, reset,
      state_ff == S_DONE && (!rsp_valid_ff || rsp_if.ready),
      rsp_valid_ff && state_ff == S_IDLE, "finished result not moved to the response register")
endmodule
